/* rtl/amx_pkg.sv */
`default_nettype none

package amx_pkg;

  // default storage sizes
  localparam int WORD_BITS_DEF = 24;
  localparam int ADDR_BITS_DEF = 12;

  // fixed field widths on the stream ports
  localparam int REQ_W      = 5;
  localparam int MODE_W     = 2;
  localparam int ADDRESS_W  = 12;
  localparam int PRELOAD_W  = 24;
  localparam int ACC_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PRELOAD = 5'd0;
  localparam logic [REQ_W-1:0] REQ_HALT    = 5'd1;
  localparam logic [REQ_W-1:0] REQ_NOP     = 5'd2;
  localparam logic [REQ_W-1:0] REQ_LD      = 5'd3;
  localparam logic [REQ_W-1:0] REQ_ST      = 5'd4;
  localparam logic [REQ_W-1:0] REQ_EM      = 5'd5;
  localparam logic [REQ_W-1:0] REQ_ADD     = 5'd6;
  localparam logic [REQ_W-1:0] REQ_SUB     = 5'd7;
  localparam logic [REQ_W-1:0] REQ_CLR     = 5'd8;
  localparam logic [REQ_W-1:0] REQ_COM     = 5'd9;
  localparam logic [REQ_W-1:0] REQ_AND     = 5'd10;
  localparam logic [REQ_W-1:0] REQ_OR      = 5'd11;
  localparam logic [REQ_W-1:0] REQ_XOR     = 5'd12;
  localparam logic [REQ_W-1:0] REQ_J       = 5'd13;
  localparam logic [REQ_W-1:0] REQ_JZ      = 5'd14;
  localparam logic [REQ_W-1:0] REQ_JN      = 5'd15;
  localparam logic [REQ_W-1:0] REQ_JP      = 5'd16;

  // addressing modes
  localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IMM     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNIMPL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd4;

  // execute decisions handed from the ALU to the pipeline
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                wr_en;
    logic                halt_set;
  } amx_ctl_t;

endpackage

`default_nettype wire

/* rtl/accumulator_machine_execute_unit.sv */
`default_nettype none

// Execute stage of a small accumulator machine.
//
// s_axis carries one decoded instruction or one preload word per word:
//   req_type, addr_mode, address, preload_data (see tdata port comment).
// m_axis returns one word per input word: the accumulator after that item
//   and a status code (ok, halt, unimplemented mode, illegal mode, refused).
//
// Timing: an accepted word starts its store read at once; the result is
// computed in the next cycle and lands in the output register, which drives
// m_axis_tvalid. Throughput is one word per cycle while the output is not
// stalled, set by the single read port and single write port of the word store.
// A store write in the execute cycle that hits the address being read in the
// same cycle is forwarded, so back-to-back ST/LD to one address works.
//
// Reset (rst, synchronous): accumulator cleared, halt flag cleared, both
// pipeline slots emptied. The word store is not cleared; its words are
// defined once written by preload, ST or EM.
// Stall: when m_axis_tready is low with a result pending and an item waiting
// in the execute slot, s_axis_tready drops until the output is taken.
// After HALT or a mode error every later item gets status "refused".
module accumulator_machine_execute_unit #(
  parameter int WORD_BITS = amx_pkg::WORD_BITS_DEF,
  parameter int ADDR_BITS = amx_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [4:0] req_type, [6:5] addr_mode, [18:7] address, [42:19] preload_data,
  // [47:43] zero
  input  wire logic [amx_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [23:0] acc_value, [26:24] status, [31:27] zero
  output logic      [amx_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import amx_pkg::*;

  localparam int DEPTH   = 2 ** ADDR_BITS;
  localparam int AEXT_W  = (ADDR_BITS > ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int PEXT_W  = (WORD_BITS > PRELOAD_W) ? WORD_BITS : PRELOAD_W;
  localparam int OEXT_W  = (WORD_BITS > ACC_W) ? WORD_BITS : ACC_W;

  // field unpack
  logic [REQ_W-1:0]     in_req;
  logic [MODE_W-1:0]    in_mode;
  logic [ADDRESS_W-1:0] in_address;
  logic [PRELOAD_W-1:0] in_preload;
  logic [AEXT_W-1:0]    in_addr_ext;
  logic [PEXT_W-1:0]    in_pre_ext;
  logic [ADDR_BITS-1:0] in_addr;

  assign in_req      = s_axis_tdata[4:0];
  assign in_mode     = s_axis_tdata[6:5];
  assign in_address  = s_axis_tdata[18:7];
  assign in_preload  = s_axis_tdata[42:19];
  assign in_addr_ext = AEXT_W'(in_address);
  assign in_addr     = in_addr_ext[ADDR_BITS-1:0];
  assign in_pre_ext  = PEXT_W'(in_preload);

  // execute slot
  logic                 s1_valid;
  logic [REQ_W-1:0]     s1_req;
  logic [MODE_W-1:0]    s1_mode;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [WORD_BITS-1:0] s1_pre;

  // forwarding of a write that overlapped the read
  logic                 fwd_hit;
  logic [WORD_BITS-1:0] fwd_data;

  // architectural state
  logic [WORD_BITS-1:0] acc;
  logic                 halted;

  // output register
  logic                 out_valid;
  logic [ACC_W-1:0]     out_acc;
  logic [STATUS_W-1:0]  out_status;

  logic                 in_fire;
  logic                 adv;
  logic                 wr_en;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] mem_data;
  logic [WORD_BITS-1:0] acc_next;
  logic [WORD_BITS-1:0] wr_data;
  logic [OEXT_W-1:0]    acc_ext;
  amx_ctl_t             ctl;

  // execute fires when the output register is free or being drained
  assign adv           = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wr_en         = adv && ctl.wr_en;
  assign mem_data      = fwd_hit ? fwd_data : rd_data;

  amx_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  amx_alu #(
    .WORD_BITS (WORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_alu (
    .req      (s1_req),
    .mode     (s1_mode),
    .addr     (s1_addr),
    .pre      (s1_pre),
    .acc      (acc),
    .mem_data (mem_data),
    .halted   (halted),
    .ctl      (ctl),
    .acc_next (acc_next),
    .wr_data  (wr_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      halted    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        acc       <= acc_next;
        if (ctl.halt_set) begin
          halted <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  assign acc_ext = OEXT_W'(acc_next);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req   <= in_req;
      s1_mode  <= in_mode;
      s1_addr  <= in_addr;
      s1_pre   <= in_pre_ext[WORD_BITS-1:0];
      // store write this cycle lands after the read just issued
      fwd_hit  <= wr_en && (s1_addr == in_addr);
      fwd_data <= wr_data;
    end
    if (adv) begin
      out_acc    <= acc_ext[ACC_W-1:0];
      out_status <= ctl.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - ACC_W - STATUS_W)'(0), out_status, out_acc};

  // halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  // nothing reaches the store once halted
  a_no_write_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !wr_en)
    else $error("store write while halted");

  // refused items leave the accumulator alone
  a_refused_acc: assert property (@(posedge clk) disable iff (rst)
    (adv && halted) |=> (acc == $past(acc)) && (out_status == ST_REFUSED))
    else $error("refused item changed accumulator or status");

  // an accepted item always occupies the execute slot next cycle
  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item lost before execute");

  // a result is produced only from an occupied execute slot
  a_out_from_slot: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without an item");

endmodule

`default_nettype wire

/* rtl/amx_ram.sv */
`default_nettype none

module amx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/amx_alu.sv */
`default_nettype none

module amx_alu #(
  parameter int WORD_BITS = 24,
  parameter int ADDR_BITS = 12
) (
  input  wire logic [amx_pkg::REQ_W-1:0]  req,
  input  wire logic [amx_pkg::MODE_W-1:0] mode,
  input  wire logic [ADDR_BITS-1:0]       addr,
  input  wire logic [WORD_BITS-1:0]       pre,
  input  wire logic [WORD_BITS-1:0]       acc,
  input  wire logic [WORD_BITS-1:0]       mem_data,
  input  wire logic                       halted,
  output amx_pkg::amx_ctl_t               ctl,
  output logic      [WORD_BITS-1:0]       acc_next,
  output logic      [WORD_BITS-1:0]       wr_data
);

  import amx_pkg::*;

  function automatic logic [STATUS_W-1:0] check_direct(input logic [MODE_W-1:0] m);
    logic [STATUS_W-1:0] s;
    case (m)
      MODE_DIRECT:  s = ST_OK;
      MODE_INDEXED: s = ST_UNIMPL;
      default:      s = ST_ILLEGAL;
    endcase
    return s;
  endfunction

  function automatic logic [STATUS_W-1:0] check_dir_imm(input logic [MODE_W-1:0] m);
    logic [STATUS_W-1:0] s;
    case (m)
      MODE_DIRECT, MODE_IMM: s = ST_OK;
      MODE_INDEXED:          s = ST_UNIMPL;
      default:               s = ST_ILLEGAL;
    endcase
    return s;
  endfunction

  logic [WORD_BITS-1:0] opnd;

  // immediate operand is the address, zero-extended or cut to the word
  assign opnd = (mode == MODE_DIRECT) ? mem_data : WORD_BITS'(addr);

  always_comb begin
    ctl.status   = ST_OK;
    ctl.wr_en    = 1'b0;
    acc_next     = acc;
    wr_data      = acc;
    if (halted) begin
      ctl.status = ST_REFUSED;
    end else begin
      unique case (req) inside
        REQ_PRELOAD: begin
          ctl.wr_en = 1'b1;
          wr_data   = pre;
        end
        REQ_HALT: begin
          ctl.status = ST_HALT;
        end
        REQ_ST, REQ_EM, REQ_J, REQ_JZ, REQ_JN, REQ_JP: begin
          ctl.status = check_direct(mode);
          if (ctl.status == ST_OK && req == REQ_ST) begin
            ctl.wr_en = 1'b1;
          end else if (ctl.status == ST_OK && req == REQ_EM) begin
            ctl.wr_en = 1'b1;
            acc_next  = mem_data;
          end
        end
        REQ_LD, REQ_ADD, REQ_SUB, REQ_AND, REQ_OR, REQ_XOR: begin
          ctl.status = check_dir_imm(mode);
          if (ctl.status == ST_OK) begin
            case (req)
              REQ_LD:  acc_next = opnd;
              REQ_ADD: acc_next = acc + opnd;
              REQ_SUB: acc_next = acc - opnd;
              REQ_AND: acc_next = acc & opnd;
              REQ_OR:  acc_next = acc | opnd;
              default: acc_next = acc ^ opnd;
            endcase
          end
        end
        REQ_CLR: begin
          acc_next = '0;
        end
        REQ_COM: begin
          acc_next = ~acc;
        end
        default: begin
          // NOP and unused codes
          acc_next = acc;
        end
      endcase
    end
    ctl.halt_set = (ctl.status == ST_HALT) || (ctl.status == ST_UNIMPL) ||
                   (ctl.status == ST_ILLEGAL);
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

// Execute-unit testbench: directed words, a long random stream of legal
// instructions, a drain-and-resume check and the sticky halt at the very end.
// Expected results come from an in-bench copy of the accumulator, store and halt flag.
module tb;
  import amx_pkg::*;

  localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
  localparam int RANDOM_WORDS = 1760;
  localparam int REFUSED_WORDS = 30;
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 5'd17;  // first unused request code
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 5'd31;

  typedef struct packed {
    logic [ACC_W-1:0]    acc;
    logic [STATUS_W-1:0] status;
  } exec_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tready = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;

  // random idling on each side; cleared for a stretch of the random test
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  // mirror of the execute state
  logic [ACC_W-1:0] acc_mirror;
  logic [ACC_W-1:0] store_mirror [0:4095];
  bit               halted_mirror;
  bit               written [0:4095];
  logic [11:0]      written_addrs [$];
  logic [11:0]      last_written;

  exec_result_t pending_results [$];
  exec_result_t want;
  int unsigned  mismatches   = 0;
  int unsigned  stall_cycles = 0;

  accumulator_machine_execute_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [STATUS_W-1:0] check_mode(logic [MODE_W-1:0] mode, bit imm_ok);
    if (mode == MODE_DIRECT || (imm_ok && mode == MODE_IMM)) return ST_OK;
    if (mode == MODE_INDEXED) return ST_UNIMPL;
    return ST_ILLEGAL;
  endfunction

  function automatic void note_written(logic [11:0] a);
    if (!written[a]) begin
      written[a] = 1'b1;
      written_addrs.push_back(a);
    end
    last_written = a;
  endfunction

  function automatic exec_result_t execute_word(logic [REQ_W-1:0] req, logic [MODE_W-1:0] mode,
                                                logic [11:0] addr, logic [ACC_W-1:0] data);
    logic [STATUS_W-1:0] st;
    logic [ACC_W-1:0]    opnd;
    logic [ACC_W-1:0]    tmp;
    exec_result_t        r;
    st = ST_OK;
    if (halted_mirror) begin
      st = ST_REFUSED;
    end else begin
      case (req)
        REQ_PRELOAD: begin
          store_mirror[addr] = data;
          note_written(addr);
        end
        REQ_HALT: st = ST_HALT;
        REQ_ST, REQ_EM, REQ_J, REQ_JZ, REQ_JN, REQ_JP: begin
          st = check_mode(mode, 1'b0);
          if (st == ST_OK && req == REQ_ST) begin
            store_mirror[addr] = acc_mirror;
            note_written(addr);
          end else if (st == ST_OK && req == REQ_EM) begin
            tmp = acc_mirror;
            acc_mirror = store_mirror[addr];
            store_mirror[addr] = tmp;
            note_written(addr);
          end
        end
        REQ_LD, REQ_ADD, REQ_SUB, REQ_AND, REQ_OR, REQ_XOR: begin
          st = check_mode(mode, 1'b1);
          if (st == ST_OK) begin
            opnd = (mode == MODE_DIRECT) ? store_mirror[addr] : ACC_W'(addr);
            case (req)
              REQ_LD:  acc_mirror = opnd;
              REQ_ADD: acc_mirror = acc_mirror + opnd;
              REQ_SUB: acc_mirror = acc_mirror - opnd;
              REQ_AND: acc_mirror = acc_mirror & opnd;
              REQ_OR:  acc_mirror = acc_mirror | opnd;
              default: acc_mirror = acc_mirror ^ opnd;
            endcase
          end
        end
        REQ_CLR: acc_mirror = '0;
        REQ_COM: acc_mirror = ~acc_mirror;
        default: ;  // NOP and unused codes
      endcase
    end
    if (st == ST_HALT || st == ST_UNIMPL || st == ST_ILLEGAL) halted_mirror = 1'b1;
    r.acc    = acc_mirror;
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [ACC_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 24'h800000;
      default: return ACC_W'($urandom);
    endcase
  endfunction

  // reads only ever touch words already written
  function automatic logic [11:0] pick_read_addr();
    if ($urandom_range(0, 99) < 40) return last_written;
    return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
  endfunction

  // mostly a small pool so reads hit recent writes
  function automatic logic [11:0] pick_write_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return last_written;
    if (r < 60) return 12'($urandom_range(0, 15));
    if (r < 70) return 12'($urandom_range(4080, 4095));
    return 12'($urandom_range(0, 4095));
  endfunction

  // drive one word at the falling edge, hold until taken; returns at a falling edge
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [MODE_W-1:0] mode,
                           input logic [11:0] addr, input logic [ACC_W-1:0] data);
    while (tx_idle && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, data, addr, mode, req};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(execute_word(req, mode, addr, data));
    @(negedge clk);
  endtask

  // one instruction that can never halt the unit
  task automatic send_random_legal();
    int               r;
    logic [REQ_W-1:0] req;
    logic [MODE_W-1:0] mode;
    logic [11:0]      addr;
    logic [ACC_W-1:0] data;
    r    = $urandom_range(0, 99);
    data = pick_data();
    addr = 12'($urandom_range(0, 4095));
    mode = MODE_W'($urandom_range(0, 3));
    if (r < 14) begin
      req  = REQ_PRELOAD;
      addr = pick_write_addr();
    end else if (r < 50) begin
      case ($urandom_range(0, 5))
        0:       req = REQ_LD;
        1:       req = REQ_ADD;
        2:       req = REQ_SUB;
        3:       req = REQ_AND;
        4:       req = REQ_OR;
        default: req = REQ_XOR;
      endcase
      mode = $urandom_range(0, 1) ? MODE_IMM : MODE_DIRECT;
      if (mode == MODE_DIRECT) begin
        addr = pick_read_addr();
      end else if ($urandom_range(0, 3) == 0) begin
        addr = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
    end else if (r < 62) begin
      req  = REQ_ST;
      mode = MODE_DIRECT;
      addr = pick_write_addr();
    end else if (r < 70) begin
      req  = REQ_EM;
      mode = MODE_DIRECT;
      addr = pick_read_addr();
    end else if (r < 76) begin
      req  = REQ_W'(REQ_J + $urandom_range(0, 3));
      mode = MODE_DIRECT;
      addr = pick_read_addr();
    end else if (r < 82) begin
      req = REQ_CLR;
    end else if (r < 90) begin
      req = REQ_COM;
    end else if (r < 94) begin
      req = REQ_NOP;
    end else begin
      req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end
    send_word(req, mode, addr, data);
  endtask

  // sender holds off until every expected word is back
  task automatic wait_until_empty();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_ops();
    send_word(REQ_PRELOAD, MODE_BAD, 12'h000, 24'hFFFFFF);  // preload ignores the mode
    send_word(REQ_PRELOAD, MODE_DIRECT, 12'hFFF, 24'h000001);
    send_word(REQ_PRELOAD, MODE_INDEXED, 12'h001, 24'h000000);
    send_word(REQ_LD,  MODE_DIRECT, 12'h000, 24'h0);
    send_word(REQ_ADD, MODE_DIRECT, 12'hFFF, 24'h0);         // wraps to zero
    send_word(REQ_SUB, MODE_IMM,    12'h001, 24'h0);         // borrows to all ones
    send_word(REQ_ADD, MODE_IMM,    12'hFFF, 24'hFFFFFF);
    send_word(REQ_AND, MODE_DIRECT, 12'h000, 24'h0);
    send_word(REQ_OR,  MODE_IMM,    12'hAAA, 24'h0);
    send_word(REQ_XOR, MODE_DIRECT, 12'hFFF, 24'h0);
    send_word(REQ_ST,  MODE_DIRECT, 12'h002, 24'h0);
    send_word(REQ_LD,  MODE_DIRECT, 12'h002, 24'h0);         // read right after write
    send_word(REQ_EM,  MODE_DIRECT, 12'h001, 24'h0);
    send_word(REQ_LD,  MODE_DIRECT, 12'h001, 24'h0);
    send_word(REQ_COM, MODE_INDEXED, 12'h123, 24'h0);        // bad mode ignored here
    send_word(REQ_CLR, MODE_BAD,     12'hFFF, 24'h0);
    send_word(REQ_NOP, MODE_IMM,     12'h555, 24'hFFFFFF);
    send_word(REQ_SPARE_LO, MODE_INDEXED, 12'h000, 24'h0);
    send_word(REQ_SPARE_HI, MODE_BAD,     12'hFFF, 24'hFFFFFF);
    send_word(REQ_J,   MODE_DIRECT, 12'h000, 24'h0);
    send_word(REQ_JZ,  MODE_DIRECT, 12'hFFF, 24'h0);
    send_word(REQ_JN,  MODE_DIRECT, 12'h001, 24'h0);
    send_word(REQ_JP,  MODE_DIRECT, 12'h002, 24'h0);
    send_word(REQ_EM,  MODE_DIRECT, 12'h002, 24'h0);
  endtask

  task automatic test_random_ops();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_idle = !(i >= 700 && i < 1000);  // back-to-back stretch
      rx_idle = tx_idle;
      send_random_legal();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_hold_until_empty();
    repeat (30) send_random_legal();
    wait_until_empty();
    repeat (30) send_random_legal();
  endtask

  // one halting cause picked at random, then everything must be refused
  task automatic test_sticky_halt();
    logic [REQ_W-1:0]  req;
    logic [MODE_W-1:0] mode;
    logic [11:0]       addr;
    case ($urandom_range(0, 2))
      0:       req = REQ_LD;
      1:       req = REQ_ST;
      default: req = REQ_JN;
    endcase
    addr = pick_read_addr();
    case ($urandom_range(0, 5))
      0:       send_word(REQ_HALT, MODE_W'($urandom_range(0, 3)), addr, pick_data());
      1:       send_word(req, MODE_INDEXED, addr, pick_data());
      2:       send_word(req, MODE_BAD, addr, pick_data());
      3:       send_word(REQ_ST, MODE_IMM, addr, pick_data());
      4:       send_word(REQ_EM, MODE_IMM, addr, pick_data());
      default: send_word(REQ_W'(REQ_J + $urandom_range(0, 3)), MODE_IMM, addr, pick_data());
    endcase
    repeat (REFUSED_WORDS) begin
      req  = REQ_W'($urandom_range(0, 31));
      mode = MODE_W'($urandom_range(0, 3));
      addr = (req == REQ_PRELOAD || mode != MODE_DIRECT) ? 12'($urandom_range(0, 4095))
                                                        : pick_read_addr();
      send_word(req, mode, addr, pick_data());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= rx_idle ? ($urandom_range(0, 99) >= 35) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: acc %h status %0d", m_tdata[23:0], m_tdata[26:24]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[23:0] !== want.acc || m_tdata[26:24] !== want.status) begin
          if (mismatches < 10)
            $display("result mismatch: acc exp %h got %h, status exp %0d got %0d",
                     want.acc, m_tdata[23:0], want.status, m_tdata[26:24]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    acc_mirror    = '0;
    halted_mirror = 1'b0;
    last_written  = 12'h000;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_ops();
    test_random_ops();
    test_hold_until_empty();
    test_sticky_halt();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // catch any stray extra word
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/amx_pkg.sv
rtl/amx_ram.sv
rtl/amx_alu.sv
rtl/accumulator_machine_execute_unit.sv
verif/tb.sv
